// ===== sv/tpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tpq_pkg;

  localparam int unsigned KEY_W          = 8;
  localparam logic [KEY_W-1:0] THRESHOLD_RESET = 8'd60;

  typedef enum logic {
    KIND_ENQUEUE = 1'b0,
    KIND_SERVE   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cell control: load the new key, or take the neighbor's entry
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/tpq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tpq_req_if;
  import tpq_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, kind, key_value, input ready);
  modport sink   (input valid, kind, key_value, output ready);
endinterface

interface tpq_rsp_if;
  import tpq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] served_value;
  logic             served_preferred;

  modport source (output valid, status, served_value, served_preferred, input ready);
  modport sink   (input valid, status, served_value, served_preferred, output ready);
endinterface
`default_nettype wire

// ===== sv/tpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpq_cell (
  input  wire                        clk,
  input  tpq_pkg::cell_ctl_t         ctl,
  input  wire [tpq_pkg::KEY_W-1:0]   key_in,
  input  wire [tpq_pkg::KEY_W-1:0]   next_in,
  output logic [tpq_pkg::KEY_W-1:0]  data_out
);
  import tpq_pkg::*;

  logic [KEY_W-1:0] data_r;
  logic [KEY_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = key_in;
    end else if (ctl.shift) begin
      data_nxt = next_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule
`default_nettype wire

// ===== sv/tpq_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One class FIFO as a row of cells; cell 0 holds the oldest entry.
module tpq_chain #(
  parameter int unsigned QUEUE_DEPTH = 128,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire                        pop,
  input  wire [tpq_pkg::KEY_W-1:0]   key_in,
  output logic [tpq_pkg::KEY_W-1:0]  head_data,
  output logic [CNT_W-1:0]           count,
  output logic                       full,
  output logic                       empty
);
  import tpq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [KEY_W-1:0] cell_data [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [KEY_W-1:0] nb;

    // a key lands in the first free cell; a pop moves every cell one step to the head
    assign ctl.load  = push && (count_r == CNT_W'(i));
    assign ctl.shift = pop;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end

    tpq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key_in   (key_in),
      .next_in  (nb),
      .data_out (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_data = cell_data[0];
  assign count     = count_r;
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

endmodule
`default_nettype wire

// ===== sv/two_class_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port group   Dir  Handshake      Payload
// in_req       in   valid/ready    kind, key_value
// out_rsp      out  valid/ready    status, served_value, served_preferred
// cfg_*        in   cfg_we         cfg_wdata (priority threshold)
//
// One request accepted per cycle while in_req.ready is high; its response is
// registered and shows in the cycle after acceptance. Each class is a row of
// QUEUE_DEPTH cells: a push writes the first free cell, a pop shifts the whole
// row one cell. in_req.ready drops only while a response waits and out_rsp.ready
// is low. Reset clears the counts, the threshold (to 60) and the response valid;
// cell contents are not cleared and there is no clearing pass.
module two_class_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  wire                       clk,
  input  wire                       rst_n,
  tpq_req_if.sink                   in_req,
  tpq_rsp_if.source                 out_rsp,
  input  wire                       cfg_we,
  input  wire [tpq_pkg::KEY_W-1:0]  cfg_wdata
);
  import tpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [KEY_W-1:0] thr_r;
  logic             out_valid_r;
  status_t          status_r,  status_nxt;
  logic [KEY_W-1:0] value_r,   value_nxt;
  logic             pref_r,    pref_nxt;

  logic             accept, is_enq, is_serve, is_pref;
  logic             push_p, push_n, pop_p, pop_n;
  logic [KEY_W-1:0] head_p, head_n;
  logic [CNT_W-1:0] count_p, count_n;
  logic             full_p, full_n, empty_p, empty_n;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign is_enq       = accept && (kind_t'(in_req.kind) == KIND_ENQUEUE);
  assign is_serve     = accept && (kind_t'(in_req.kind) == KIND_SERVE);
  assign is_pref      = (in_req.key_value >= thr_r);

  assign push_p = is_enq && is_pref && !full_p;
  assign push_n = is_enq && !is_pref && !full_n;
  assign pop_p  = is_serve && !empty_p;
  assign pop_n  = is_serve && empty_p && !empty_n;

  tpq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pref (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_p),
    .pop       (pop_p),
    .key_in    (in_req.key_value),
    .head_data (head_p),
    .count     (count_p),
    .full      (full_p),
    .empty     (empty_p)
  );

  tpq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_n),
    .pop       (pop_n),
    .key_in    (in_req.key_value),
    .head_data (head_n),
    .count     (count_n),
    .full      (full_n),
    .empty     (empty_n)
  );

  always_comb begin
    status_nxt = ST_DONE;
    value_nxt  = '0;
    pref_nxt   = 1'b0;
    if (kind_t'(in_req.kind) == KIND_ENQUEUE) begin
      pref_nxt   = is_pref;
      status_nxt = (is_pref ? full_p : full_n) ? ST_FULL : ST_DONE;
    end else if (!empty_p) begin
      value_nxt = head_p;
      pref_nxt  = 1'b1;
    end else if (!empty_n) begin
      value_nxt = head_n;
    end else begin
      status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      pref_r   <= pref_nxt;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.status           = status_r;
  assign out_rsp.served_value     = value_r;
  assign out_rsp.served_preferred = pref_r;

  a_pref_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_p |=> count_p == $past(count_p) + CNT_W'(1))
    else $error("preferred count did not advance on push");

  a_norm_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_n |=> count_n == $past(count_n) - CNT_W'(1))
    else $error("normal count did not drop on pop");

  a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_p && pop_n))
    else $error("both queues popped by one request");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (is_serve && empty_p && empty_n) |=> out_rsp.valid && out_rsp.status == ST_EMPTY)
    else $error("serve on empty queues not reported as empty");

endmodule
`default_nettype wire
